### sv/fla_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free list allocator.
// ---------------------------------------------------------------------------
package fla_pkg;

  localparam int MAX_FREE_NODES = 32;
  localparam int MAX_BLOCKS     = 32;
  localparam int ALIGN_BYTES    = 8;
  localparam int NODE_BYTES     = 16;
  localparam int HEADER_BYTES   = 8;
  localparam int PAGE_BYTES     = 4096;

  localparam int FREE_AW  = $clog2(MAX_FREE_NODES);
  localparam int BLK_AW   = $clog2(MAX_BLOCKS);
  localparam int CNT_W    = $clog2(MAX_FREE_NODES + 1);
  localparam int REM_W    = $clog2((MAX_FREE_NODES > MAX_BLOCKS ?
                                    MAX_FREE_NODES : MAX_BLOCKS) + 1);
  localparam int IDX_W    = (FREE_AW > BLK_AW) ? FREE_AW : BLK_AW;
  localparam int PAGE_SH  = $clog2(PAGE_BYTES);

  localparam int OFF_W    = 20;
  localparam int SIZE_W   = 21;
  localparam int REQ_W    = 21;
  localparam int WIDE_W   = 22;
  localparam int PAGES_W  = 9;
  localparam int ENTRY_W  = OFF_W + SIZE_W;

  localparam logic [PAGES_W-1:0] PAGES_MAX   = 9'd256;
  localparam logic [PAGES_W-1:0] PAGES_RESET = 9'd16;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_BAD_POINTER = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    POL_BEST  = 2'd0,
    POL_WORST = 2'd1,
    POL_FIRST = 2'd2,
    POL_NONE  = 2'd3
  } policy_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ASCAN,
    S_AFIN,
    S_BSCAN,
    S_BFIN,
    S_FSCAN,
    S_MERGE,
    S_SHDN,
    S_SHUP,
    S_HEAD,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [OFF_W-1:0]  user_offset;
  } result_t;

endpackage
`default_nettype wire

### sv/fla_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fla_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module fla_ram #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/fla_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fla_ctrl
// Sequencer: scans the free and block tables, carves, merges and shifts.
// ---------------------------------------------------------------------------
module fla_ctrl import fla_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [REQ_W-1:0]   request_bytes,
  input  wire logic [1:0]         fit_policy,
  input  wire logic [OFF_W-1:0]   block_offset,
  input  wire logic               cfg_valid,
  input  wire logic [PAGES_W-1:0] cfg_data,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res
);

  state_t state, state_next;

  // free table and block table ports
  logic               f_we;
  logic [FREE_AW-1:0] f_waddr;
  logic [ENTRY_W-1:0] f_wdata, f_rdata;
  logic               b_we;
  logic [BLK_AW-1:0]  b_waddr;
  logic [ENTRY_W-1:0] b_wdata, b_rdata;

  logic [PAGES_W-1:0]    region_pages;
  logic                  init_pend;
  logic [CNT_W-1:0]      free_count;
  logic [MAX_BLOCKS-1:0] block_valid;

  // scan engine
  logic [IDX_W-1:0] idx, tag_idx;
  logic [REM_W-1:0] rem;
  logic             dir_down;
  logic             tag_v;

  // item
  logic [1:0]        pol;
  logic [WIDE_W-1:0] tot;
  logic [OFF_W-1:0]  off;

  logic               found;
  logic [FREE_AW-1:0] pick;
  logic [OFF_W-1:0]   pick_start;
  logic [SIZE_W-1:0]  pick_size;

  logic               hit;
  logic [BLK_AW-1:0]  slot;
  logic [OFF_W-1:0]   bstart;
  logic [SIZE_W-1:0]  bsize;
  logic               f_hit, j_hit;
  logic [FREE_AW-1:0] f_idx, j_idx;
  logic [SIZE_W-1:0]  f_size, j_size;
  logic [OFF_W-1:0]   j_start;

  status_t          res_status;
  logic [OFF_W-1:0] res_off;

  logic [PAGES_W-1:0] pages_cl;
  logic [SIZE_W-1:0]  region_bytes;
  logic [WIDE_W-1:0]  req_tot, tot_raw;
  logic [WIDE_W-1:0]  new_end;
  logic [SIZE_W-1:0]  n_size;
  logic               slot_free;
  logic [BLK_AW-1:0]  free_slot;
  logic               scan_done;
  logic               in_fire;

  logic [OFF_W-1:0]  r_start;
  logic [SIZE_W-1:0] r_size;
  logic [WIDE_W-1:0] r_end;

  fla_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_FREE_NODES)) u_free (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(idx[FREE_AW-1:0]), .rdata(f_rdata)
  );

  fla_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_blk (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .raddr(idx[BLK_AW-1:0]), .rdata(b_rdata)
  );

  assign pages_cl = (region_pages == '0) ? PAGES_W'(1) :
                    (region_pages > PAGES_MAX) ? PAGES_MAX : region_pages;
  assign region_bytes = SIZE_W'({pages_cl, {PAGE_SH{1'b0}}}) - SIZE_W'(NODE_BYTES);

  assign tot_raw = ((WIDE_W'(request_bytes) + WIDE_W'(ALIGN_BYTES - 1))
                    & ~WIDE_W'(ALIGN_BYTES - 1)) + WIDE_W'(HEADER_BYTES);
  assign req_tot = (tot_raw < WIDE_W'(NODE_BYTES)) ? WIDE_W'(NODE_BYTES) : tot_raw;

  assign r_start = f_rdata[ENTRY_W-1:SIZE_W];
  assign r_size  = f_rdata[SIZE_W-1:0];
  assign r_end   = WIDE_W'(r_start) + WIDE_W'(NODE_BYTES) + WIDE_W'(r_size);

  assign new_end = WIDE_W'(bstart) + WIDE_W'(bsize) + WIDE_W'(HEADER_BYTES);
  assign n_size  = SIZE_W'(WIDE_W'(bsize) + WIDE_W'(HEADER_BYTES) - WIDE_W'(NODE_BYTES)
                   + (f_hit ? WIDE_W'(f_size) + WIDE_W'(NODE_BYTES) : '0));

  always_comb begin
    slot_free = 1'b0;
    free_slot = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!block_valid[i]) begin
        slot_free = 1'b1;
        free_slot = BLK_AW'(i);
      end
    end
  end

  assign scan_done = (rem == '0) && !tag_v;
  assign in_ready  = (state == S_IDLE) && !init_pend;
  assign in_fire   = in_valid && in_ready;
  assign res_valid = (state == S_DONE);
  assign res.status = res_status;
  assign res.user_offset = res_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    f_we    = 1'b0;
    f_waddr = '0;
    f_wdata = '0;
    b_we    = 1'b0;
    b_waddr = free_slot;
    b_wdata = {pick_start, SIZE_W'(tot - WIDE_W'(HEADER_BYTES))};
    if (init_pend) begin
      f_we    = 1'b1;
      f_wdata = {OFF_W'(0), region_bytes};
    end
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          state_next = (kind == KIND_FREE) ? S_BSCAN : S_ASCAN;
        end
      end
      S_ASCAN: if (scan_done) state_next = S_AFIN;
      S_AFIN: begin
        if (found && slot_free) begin
          f_we    = 1'b1;
          f_waddr = pick;
          f_wdata = {OFF_W'(WIDE_W'(pick_start) + tot),
                     SIZE_W'(WIDE_W'(pick_size) - tot)};
          b_we    = 1'b1;
        end
        state_next = S_DONE;
      end
      S_BSCAN: if (scan_done) state_next = S_BFIN;
      S_BFIN: begin
        if (!hit || free_count >= CNT_W'(MAX_FREE_NODES)) begin
          state_next = S_DONE;
        end else begin
          state_next = S_FSCAN;
        end
      end
      S_FSCAN: begin
        if (scan_done) state_next = j_hit ? S_MERGE : S_SHUP;
      end
      S_MERGE: begin
        f_we    = 1'b1;
        f_waddr = j_idx;
        f_wdata = {j_start, SIZE_W'(WIDE_W'(j_size) + WIDE_W'(n_size)
                                    + WIDE_W'(NODE_BYTES))};
        state_next = f_hit ? S_SHDN : S_DONE;
      end
      S_SHDN: begin
        f_we    = tag_v;
        f_waddr = FREE_AW'(tag_idx) - FREE_AW'(1);
        f_wdata = f_rdata;
        if (scan_done) state_next = S_DONE;
      end
      S_SHUP: begin
        f_we    = tag_v;
        f_waddr = FREE_AW'(tag_idx) + FREE_AW'(1);
        f_wdata = f_rdata;
        if (scan_done) state_next = S_HEAD;
      end
      S_HEAD: begin
        f_we    = 1'b1;
        f_waddr = '0;
        f_wdata = {bstart, n_size};
        state_next = S_DONE;
      end
      S_DONE: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_pages <= PAGES_RESET;
      init_pend    <= 1'b1;
      free_count   <= CNT_W'(1);
      block_valid  <= '0;
      rem          <= '0;
      tag_v        <= 1'b0;
    end else begin
      if (init_pend) init_pend <= 1'b0;
      if (cfg_valid) begin
        region_pages <= cfg_data;
        init_pend    <= 1'b1;
        free_count   <= CNT_W'(1);
        block_valid  <= '0;
      end

      // read pipeline: issue one address a cycle, tag the registered read data with its index
      tag_v   <= (rem != '0);
      tag_idx <= idx;
      if (rem != '0) begin
        rem <= rem - REM_W'(1);
        idx <= dir_down ? idx - IDX_W'(1) : idx + IDX_W'(1);
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            pol      <= fit_policy;
            tot      <= req_tot;
            off      <= block_offset;
            found    <= 1'b0;
            hit      <= 1'b0;
            f_hit    <= 1'b0;
            j_hit    <= 1'b0;
            idx      <= '0;
            dir_down <= 1'b0;
            rem      <= (kind == KIND_FREE) ? REM_W'(MAX_BLOCKS) : REM_W'(free_count);
          end
        end
        S_ASCAN: begin
          if (tag_v && pol != POL_NONE && WIDE_W'(r_size) >= tot) begin
            if (!found || (pol == POL_BEST && r_size < pick_size) ||
                (pol == POL_WORST && r_size > pick_size)) begin
              found      <= 1'b1;
              pick       <= FREE_AW'(tag_idx);
              pick_start <= r_start;
              pick_size  <= r_size;
            end
          end
        end
        S_AFIN: begin
          res_off <= '0;
          if (!found) begin
            res_status <= ST_NO_SPACE;
          end else if (!slot_free) begin
            res_status <= ST_TABLE_FULL;
          end else begin
            res_status             <= ST_OK;
            res_off                <= OFF_W'(WIDE_W'(pick_start) + WIDE_W'(HEADER_BYTES));
            block_valid[free_slot] <= 1'b1;
          end
        end
        S_BSCAN: begin
          if (tag_v && !hit && block_valid[BLK_AW'(tag_idx)] &&
              WIDE_W'(b_rdata[ENTRY_W-1:SIZE_W]) + WIDE_W'(HEADER_BYTES)
              == WIDE_W'(off)) begin
            hit    <= 1'b1;
            slot   <= BLK_AW'(tag_idx);
            bstart <= b_rdata[ENTRY_W-1:SIZE_W];
            bsize  <= b_rdata[SIZE_W-1:0];
          end
        end
        S_BFIN: begin
          res_off <= '0;
          if (!hit) begin
            res_status <= ST_BAD_POINTER;
          end else if (free_count >= CNT_W'(MAX_FREE_NODES)) begin
            res_status <= ST_TABLE_FULL;
          end else begin
            res_status <= ST_OK;
            idx        <= '0;
            dir_down   <= 1'b0;
            rem        <= REM_W'(free_count);
          end
        end
        S_FSCAN: begin
          if (tag_v) begin
            if (!f_hit && WIDE_W'(r_start) == new_end) begin
              f_hit  <= 1'b1;
              f_idx  <= FREE_AW'(tag_idx);
              f_size <= r_size;
            end
            if (!j_hit && r_end == WIDE_W'(bstart)) begin
              j_hit   <= 1'b1;
              j_idx   <= FREE_AW'(tag_idx);
              j_size  <= r_size;
              j_start <= r_start;
            end
          end
          if (scan_done) begin
            block_valid[slot] <= 1'b0;
            if (!j_hit) begin
              // open the head slot: shift the entries below the absorbed node (all if none) up
              dir_down <= 1'b1;
              if (f_hit) begin
                idx <= IDX_W'(f_idx) - IDX_W'(1);
                rem <= REM_W'(f_idx);
              end else begin
                idx <= IDX_W'(free_count - CNT_W'(1));
                rem <= REM_W'(free_count);
              end
            end
          end
        end
        S_MERGE: begin
          if (f_hit) begin
            // close the gap left by the absorbed following node
            dir_down   <= 1'b0;
            idx        <= IDX_W'(f_idx) + IDX_W'(1);
            rem        <= REM_W'(free_count - CNT_W'(1) - CNT_W'(f_idx));
            free_count <= free_count - CNT_W'(1);
          end
        end
        S_HEAD: begin
          if (!f_hit) free_count <= free_count + CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/free_list_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// free_list_allocator
// Free list allocator with first, best and worst fit over one region.
// ---------------------------------------------------------------------------
// One item is worked at a time. An allocate makes one pass over the free
// table RAM at one entry a cycle. A free makes a pass over the block table
// RAM and, for a matched block, a pass over the free table and, if needed,
// a shift of free table entries, each one RAM access a cycle. After reset or a
// region_pages write, the first free node is rebuilt before the next item is
// taken. The result waits in an output register while the next item is taken.
module free_list_allocator import fla_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               kind,
  input  wire logic [REQ_W-1:0]   request_bytes,
  input  wire logic [1:0]         fit_policy,
  input  wire logic [OFF_W-1:0]   block_offset,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [OFF_W-1:0]        user_offset,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [PAGES_W-1:0] cfg_data
);

  logic    res_valid;
  logic    res_ready;
  result_t res;

  fla_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .request_bytes(request_bytes),
    .fit_policy(fit_policy), .block_offset(block_offset),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the payload until the item is taken
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status      <= res.status;
      user_offset <= res.user_offset;
    end
  end

endmodule
`default_nettype wire
